[sv/uvol_pkg.sv]
`timescale 1ns / 1ps

package uvol_pkg;

	// operation codes carried in s_tuser
	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_QUERY  = 2'd2,
		OP_POP    = 2'd3
	} op_kind_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_POP,
		S_WRITE,
		S_RESP
	} seq_state_t;

	// word layout
	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;
	localparam int COUNT_W = 7;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

endpackage

[sv/unique_value_ordered_list_core.sv]
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values, head at index 0.
// Input words arrive on the s_ side: s_tuser carries the operation
// (append unique, insert at position, query membership, pop front),
// s_tdata the value and the position. One result word leaves on the
// m_ side per input word: success flag, popped value and count after.
// One word is handled at a time; s_tready is high only while idle.
// The list sits in a single-port-write, registered-read memory and one
// sequencer walks it one entry per cycle, so the walk length sets how
// long each word takes. The next word is taken no earlier than the
// cycle after the result word leaves.
// The result word is held in a register until m_tready takes it; the
// block waits in that state and accepts nothing meanwhile.
// Reset clears the count and the sequencer; the memory is not cleared,
// since only entries below the count are ever read.
module unique_value_ordered_list_core
	import uvol_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [31:0] value, [38:32] position, [39] zero
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [1:0] kind
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] success, [32:1] popped_value, [39:33] count_after
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	seq_state_t state_q, state_d;

	logic [VALUE_W-1:0] mem [CAPACITY];
	logic [VALUE_W-1:0] rd_data_q;

	op_kind_t           kind_q;
	logic [VALUE_W-1:0] value_q;
	logic [AW-1:0]      tgt_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      end_q;
	logic               issue_done_q;
	logic [CW-1:0]      count_q;
	logic               ok_q;
	logic [VALUE_W-1:0] popped_q;

	logic               rd_pend_s1;
	logic [AW-1:0]      rd_addr_s1;
	logic               rd_last_s1;

	logic               mem_re, mem_we;
	logic [AW-1:0]      mem_wa;
	logic [VALUE_W-1:0] mem_wd;

	op_kind_t           in_kind;
	logic [VALUE_W-1:0] in_value;
	logic [POS_W-1:0]   in_pos;
	logic               accept, full, empty, pos_over, pos_at_tail, hit, arrive_last;

	// input word fields and status decode
	assign in_kind   = op_kind_t'(s_tuser);
	assign in_value  = s_tdata[VALUE_W-1:0];
	assign in_pos    = s_tdata[VALUE_W+POS_W-1:VALUE_W];
	assign accept    = s_tvalid && s_tready;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign pos_over  = (PW'(in_pos) > PW'(count_q));
	assign pos_at_tail = (PW'(in_pos) == PW'(count_q));
	assign hit       = (rd_data_q == value_q);
	assign arrive_last = rd_pend_s1 && rd_last_s1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_kind)
						OP_APPEND: begin
							if (full)
								state_d = S_RESP;
							else if (empty)
								state_d = S_WRITE;
							else
								state_d = S_SEARCH;
						end
						OP_INSERT: begin
							if (full || (!empty && pos_over))
								state_d = S_RESP;
							else if (empty || pos_at_tail)
								state_d = S_WRITE;
							else
								state_d = S_SHIFT;
						end
						OP_QUERY: state_d = empty ? S_RESP : S_SEARCH;
						default:  state_d = empty ? S_RESP : S_POP;
					endcase
				end
			end
			S_SEARCH: begin
				if (rd_pend_s1 && (hit || rd_last_s1)) begin
					if (hit || kind_q == OP_QUERY)
						state_d = S_RESP;
					else
						state_d = S_WRITE;
				end
			end
			S_SHIFT: begin
				if (arrive_last)
					state_d = S_WRITE;
			end
			S_POP: begin
				if (arrive_last)
					state_d = S_RESP;
			end
			S_WRITE: state_d = S_RESP;
			S_RESP: begin
				if (m_tready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// handshake and memory control
	always_comb begin
		s_tready = (state_q == S_IDLE);
		m_tvalid = (state_q == S_RESP);
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = tgt_q;
		mem_wd   = value_q;
		case (state_q)
			S_SEARCH: mem_re = !issue_done_q;
			S_SHIFT: begin
				mem_re = !issue_done_q;
				mem_we = rd_pend_s1;
				mem_wa = rd_addr_s1 + 1'b1;
				mem_wd = rd_data_q;
			end
			S_POP: begin
				mem_re = !issue_done_q;
				mem_we = rd_pend_s1 && (rd_addr_s1 != '0);
				mem_wa = rd_addr_s1 - 1'b1;
				mem_wd = rd_data_q;
			end
			S_WRITE: mem_we = 1'b1;
			default: ;
		endcase
	end

	assign m_tdata = {COUNT_W'(count_q), popped_q, ok_q};

	// list storage
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_data_q <= mem[idx_q];
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// read pipeline tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= mem_re;
			rd_last_s1 <= (idx_q == end_q);
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= idx_q;
	end

	// count and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			issue_done_q <= 1'b0;
		end else begin
			if (accept)
				issue_done_q <= 1'b0;
			else if (mem_re && idx_q == end_q)
				issue_done_q <= 1'b1;
			if (state_q == S_WRITE)
				count_q <= count_q + 1'b1;
			else if (state_q == S_POP && arrive_last)
				count_q <= count_q - 1'b1;
		end
	end

	// operation registers and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= in_kind;
			value_q  <= in_value;
			ok_q     <= 1'b0;
			popped_q <= '0;
			if (in_kind == OP_INSERT) begin
				tgt_q <= empty ? '0 : AW'(in_pos);
				idx_q <= AW'(count_q - 1'b1);
				end_q <= empty ? '0 : AW'(in_pos);
			end else begin
				tgt_q <= AW'(count_q);
				idx_q <= '0;
				end_q <= AW'(count_q - 1'b1);
			end
		end else begin
			// step the walk index toward its end
			if (mem_re && idx_q != end_q) begin
				if (state_q == S_SHIFT)
					idx_q <= idx_q - 1'b1;
				else
					idx_q <= idx_q + 1'b1;
			end
			if (state_q == S_SEARCH && rd_pend_s1 && hit && kind_q == OP_QUERY)
				ok_q <= 1'b1;
			if (state_q == S_WRITE)
				ok_q <= 1'b1;
			if (state_q == S_POP && rd_pend_s1 && rd_addr_s1 == '0)
				popped_q <= rd_data_q;
			if (state_q == S_POP && arrive_last)
				ok_q <= 1'b1;
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count exceeds capacity");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while a result word is pending");

	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == S_WRITE || $past(state_q) == S_POP))
		else $error("count changed outside write or pop");

	a_popped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && kind_q != OP_POP) |-> (popped_q == '0))
		else $error("popped value set on a non-pop word");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_wa) < CW'(CAPACITY)))
		else $error("write beyond list capacity");

endmodule

[sim/unique_value_ordered_list_core_tb.sv]
`timescale 1ns / 1ps

module unique_value_ordered_list_core_tb;
	import uvol_pkg::*;

	localparam int CAPACITY = 64;
	localparam int TIMEOUT_NS = 10_000_000;

	// one result word, unpacked
	typedef struct packed {
		logic                      success;
		logic signed [VALUE_W-1:0] popped;
		logic [COUNT_W-1:0]        count;
	} list_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = OP_APPEND;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// mirror of the list contents, head at index 0
	logic signed [VALUE_W-1:0] list_mirror[$];
	// results still owed by the block, oldest first
	list_result_t              owed_results[$];

	int           error_count = 0;
	int           src_idle_pct = 0;
	int           sink_stall_pct = 0;
	list_result_t got_result;
	list_result_t want_result;

	unique_value_ordered_list_core #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic bit mirror_holds(logic signed [VALUE_W-1:0] v);
		foreach (list_mirror[i]) begin
			if (list_mirror[i] == v) return 1'b1;
		end
		return 1'b0;
	endfunction

	// apply one operation to the mirror and record the result it owes
	function automatic void predict_list_op(op_kind_t kind, logic signed [VALUE_W-1:0] value,
			logic [POS_W-1:0] pos);
		list_result_t r;
		r = '0;
		case (kind)
			OP_APPEND: begin
				if (list_mirror.size() < CAPACITY && !mirror_holds(value)) begin
					list_mirror.push_back(value);
					r.success = 1'b1;
				end
			end
			OP_INSERT: begin
				if (list_mirror.size() < CAPACITY) begin
					// an empty list takes the value at the head whatever the position
					if (list_mirror.size() == 0) begin
						list_mirror.push_front(value);
						r.success = 1'b1;
					end else if (pos <= list_mirror.size()) begin
						list_mirror.insert(pos, value);
						r.success = 1'b1;
					end
				end
			end
			OP_QUERY: begin
				r.success = mirror_holds(value);
			end
			default: begin
				if (list_mirror.size() > 0) begin
					r.popped  = list_mirror.pop_front();
					r.success = 1'b1;
				end
			end
		endcase
		r.count = COUNT_W'(list_mirror.size());
		owed_results.push_back(r);
	endfunction

	// sender: called at a falling edge, returns at a falling edge
	task automatic send_word(op_kind_t kind, logic signed [VALUE_W-1:0] value,
			logic [POS_W-1:0] pos);
		while ($urandom_range(99) < src_idle_pct) @(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {1'b0, pos, value};
		s_tuser  = kind;
		do @(posedge clk); while (!s_tready);
		predict_list_op(kind, value, pos);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (owed_results.size() != 0) @(negedge clk);
	endtask

	// receiver backpressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_result.success = m_tdata[0];
			got_result.popped  = m_tdata[32:1];
			got_result.count   = m_tdata[39:33];
			if (owed_results.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, m_tdata);
				error_count++;
			end else begin
				want_result = owed_results.pop_front();
				if (got_result.success !== want_result.success) begin
					$display("%0t: success expected %0b actual %0b", $time,
						want_result.success, got_result.success);
					error_count++;
				end
				if (got_result.popped !== want_result.popped) begin
					$display("%0t: popped_value expected %0d actual %0d", $time,
						want_result.popped, got_result.popped);
					error_count++;
				end
				if (got_result.count !== want_result.count) begin
					$display("%0t: count_after expected %0d actual %0d", $time,
						want_result.count, got_result.count);
					error_count++;
				end
			end
		end
	end

	// extremes and the special cases, on an initially empty list
	task automatic test_directed();
		send_word(OP_POP,    0, 0);               // pop on empty
		send_word(OP_QUERY,  0, 0);               // query on empty
		send_word(OP_INSERT, 32'sh7fffffff, 100); // empty list, any position goes to head
		send_word(OP_APPEND, 32'sh80000000, 0);
		send_word(OP_APPEND, 32'sh80000000, 0);   // duplicate append refused
		send_word(OP_QUERY,  32'sh80000000, 0);
		send_word(OP_QUERY,  32'sh7fffffff, 0);
		send_word(OP_QUERY,  -1, 127);
		send_word(OP_INSERT, -1, 2);              // position equal to count
		send_word(OP_INSERT, 5, 4);               // one past the count
		send_word(OP_INSERT, 6, 127);             // far beyond the count
		send_word(OP_INSERT, -1, 0);              // duplicate insert allowed
		send_word(OP_INSERT, 0, 2);               // middle
		send_word(OP_APPEND, 0, 0);               // duplicate of an inner value
		send_word(OP_QUERY,  0, 64);
		send_word(OP_APPEND, 32'sh55555555, 64);
		send_word(OP_POP,    32'shaaaaaaaa, 127);
		send_word(OP_POP,    0, 0);
		send_word(OP_QUERY,  -1, 0);              // one copy of the duplicate left
		while (list_mirror.size() > 0) send_word(OP_POP, 0, 0);
		send_word(OP_POP,    0, 0);
	endtask

	// fill to capacity, then hit every refusal of a full list
	task automatic test_full_list();
		logic signed [VALUE_W-1:0] held;
		while (list_mirror.size() < CAPACITY) begin
			if ($urandom_range(3) == 0)
				send_word(OP_INSERT, $urandom,
					POS_W'($urandom_range(0, list_mirror.size())));
			else
				send_word(OP_APPEND, $urandom, 0);
		end
		held = list_mirror[$urandom_range(0, CAPACITY - 1)];
		send_word(OP_APPEND, $urandom, 0);
		send_word(OP_APPEND, held, 0);
		send_word(OP_INSERT, $urandom, 0);
		send_word(OP_INSERT, $urandom, POS_W'(CAPACITY));
		send_word(OP_QUERY,  list_mirror[CAPACITY - 1], 0);
		send_word(OP_QUERY,  held, 0);
		send_word(OP_POP,    0, 0);
		send_word(OP_INSERT, held, POS_W'(CAPACITY - 1));
		send_word(OP_POP,    0, 0);
		send_word(OP_APPEND, list_mirror[0] ^ 32'sh1, 0);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(0, 15);
			2: begin
				case ($urandom_range(3))
					0: return 32'sh80000000;
					1: return 32'sh7fffffff;
					2: return -1;
					default: return 0;
				endcase
			end
			default: begin
				if (list_mirror.size() > 0)
					return list_mirror[$urandom_range(0, list_mirror.size() - 1)];
				return $urandom_range(0, 15);
			end
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		case ($urandom_range(9))
			7: return 0;
			8: return POS_W'(list_mirror.size());
			9: return POS_W'($urandom_range(0, 127));
			default: return POS_W'($urandom_range(0, list_mirror.size()));
		endcase
	endfunction

	// random operations, alternating growth and shrink stretches
	task automatic test_random_ops(int n_items);
		int       roll;
		bit       grow;
		op_kind_t kind;
		for (int i = 0; i < n_items; i++) begin
			grow = ((i / 50) % 2) == 0;
			roll = $urandom_range(99);
			if (grow)
				kind = (roll < 45) ? OP_APPEND : (roll < 80) ? OP_INSERT :
					(roll < 95) ? OP_QUERY : OP_POP;
			else
				kind = (roll < 50) ? OP_POP : (roll < 70) ? OP_QUERY :
					(roll < 85) ? OP_APPEND : OP_INSERT;
			send_word(kind, pick_value(), pick_position());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		src_idle_pct = 0;
		sink_stall_pct = 0;
		test_directed();
		test_full_list();
		test_random_ops(320);
		wait_drained();

		src_idle_pct = 71;
		sink_stall_pct = 0;
		test_random_ops(320);
		wait_drained();

		src_idle_pct = 0;
		sink_stall_pct = 71;
		test_random_ops(320);
		wait_drained();

		src_idle_pct = 30;
		sink_stall_pct = 30;
		test_random_ops(320);

		wait_drained();
		repeat (2 * CAPACITY) @(posedge clk);
		if (error_count == 0 && owed_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[sim.f]
sv/uvol_pkg.sv
sv/unique_value_ordered_list_core.sv
sim/unique_value_ordered_list_core_tb.sv
